// File: src/console_command_line_parser_unit_defines.svh
// Assertion macros for the console command line parser.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CONSOLE_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define CONSOLE_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CCP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccp check failed");

`define CCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccp check failed");

`else

`define CCP_ASSERT_SAME(lbl, ante, cons)

`define CCP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/ccp_pkg.sv
package ccp_pkg;

  localparam int LINE_MAX_DEF  = 256;
  localparam int TOKEN_MAX_DEF = 16;

  localparam int KW_COUNT = 7;

  // keyword indexes
  localparam logic [2:0] KW_HELP   = 3'd0;
  localparam logic [2:0] KW_STATUS = 3'd1;
  localparam logic [2:0] KW_SCAN   = 3'd2;
  localparam logic [2:0] KW_WIFI   = 3'd3;
  localparam logic [2:0] KW_BLE    = 3'd4;
  localparam logic [2:0] KW_START  = 3'd5;
  localparam logic [2:0] KW_STOP   = 3'd6;

  // characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  // token kinds
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_HELP   = 3'd1;
  localparam logic [2:0] CMD_STATUS = 3'd2;
  localparam logic [2:0] CMD_SCAN   = 3'd3;
  localparam logic [2:0] CMD_OTHER  = 3'd4;

  localparam logic [1:0] MED_NONE  = 2'd0;
  localparam logic [1:0] MED_BLE   = 2'd1;
  localparam logic [1:0] MED_WIFI  = 2'd2;
  localparam logic [1:0] MED_OTHER = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_OTHER = 2'd3;

  // outcome codes
  localparam logic [3:0] OUT_BLANK      = 4'd0;
  localparam logic [3:0] OUT_HELP       = 4'd1;
  localparam logic [3:0] OUT_STATUS     = 4'd2;
  localparam logic [3:0] OUT_BLE_START  = 4'd3;
  localparam logic [3:0] OUT_BLE_STOP   = 4'd4;
  localparam logic [3:0] OUT_WIFI_UNIMP = 4'd5;
  localparam logic [3:0] OUT_NO_MEDIUM  = 4'd6;
  localparam logic [3:0] OUT_NO_ACTION  = 4'd7;
  localparam logic [3:0] OUT_BAD_MEDIUM = 4'd8;
  localparam logic [3:0] OUT_BAD_ACTION = 4'd9;
  localparam logic [3:0] OUT_BAD_CMD    = 4'd10;
  localparam logic [3:0] OUT_TOO_LONG   = 4'd11;

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      KW_HELP:   kw_len = 3'd4;
      KW_STATUS: kw_len = 3'd6;
      KW_SCAN:   kw_len = 3'd4;
      KW_WIFI:   kw_len = 3'd4;
      KW_BLE:    kw_len = 3'd3;
      KW_START:  kw_len = 3'd5;
      KW_STOP:   kw_len = 3'd4;
      default:   kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] w;
    case (k)
      KW_HELP:   w = {"HELP", 16'h0000};
      KW_STATUS: w = "STATUS";
      KW_SCAN:   w = {"SCAN", 16'h0000};
      KW_WIFI:   w = {"WIFI", 16'h0000};
      KW_BLE:    w = {"BLE", 24'h000000};
      KW_START:  w = {"START", 8'h00};
      KW_STOP:   w = {"STOP", 16'h0000};
      default:   w = '0;
    endcase
    case (pos)
      3'd0:    kw_char = w[47:40];
      3'd1:    kw_char = w[39:32];
      3'd2:    kw_char = w[31:24];
      3'd3:    kw_char = w[23:16];
      3'd4:    kw_char = w[15:8];
      3'd5:    kw_char = w[7:0];
      default: kw_char = 8'h00;
    endcase
  endfunction

endpackage

// File: src/ccp_intf.sv
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface ccp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] outcome;

  modport source (output valid, output outcome, input ready);
  modport sink   (input valid, input outcome, output ready);
endinterface

// File: src/ccp_parser.sv
module ccp_parser import ccp_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       timeout,
  output logic       emit,
  output logic [3:0] outcome
);

  localparam int LW = $clog2(LINE_MAX);
  localparam int TW = $clog2(TOKEN_MAX);
  localparam logic [LW-1:0] LEN_LAST = LW'(LINE_MAX - 1);
  localparam logic [TW-1:0] TOK_LAST = TW'(TOKEN_MAX - 1);

  typedef struct packed {
    logic [1:0]          num;
    logic                in_tok;
    logic [TW-1:0]       cnt;
    logic [KW_COUNT-1:0] live;
    logic [2:0]          cmd;
    logic [1:0]          med;
    logic [1:0]          act;
  } tok_t;

  function automatic tok_t finish(tok_t s);
    tok_t       r;
    logic       hit;
    logic [2:0] idx;
    r   = s;
    hit = 1'b0;
    idx = '0;
    // lowest matching keyword wins
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (s.live[k] && s.cnt == TW'(kw_len(3'(k)))) begin
        hit = 1'b1;
        idx = 3'(k);
      end
    end
    if (s.in_tok) begin
      r.in_tok = 1'b0;
      r.cnt    = '0;
      r.live   = '0;
      case (s.num)
        2'd0: begin
          r.cmd = CMD_OTHER;
          if (hit && idx == KW_HELP)   r.cmd = CMD_HELP;
          if (hit && idx == KW_STATUS) r.cmd = CMD_STATUS;
          if (hit && idx == KW_SCAN)   r.cmd = CMD_SCAN;
        end
        2'd1: begin
          r.med = MED_OTHER;
          if (hit && idx == KW_BLE)  r.med = MED_BLE;
          if (hit && idx == KW_WIFI) r.med = MED_WIFI;
        end
        2'd2: begin
          r.act = ACT_OTHER;
          if (hit && idx == KW_START) r.act = ACT_START;
          if (hit && idx == KW_STOP)  r.act = ACT_STOP;
        end
        default: ;
      endcase
      if (s.num != 2'd3) r.num = s.num + 2'd1;
    end
    return r;
  endfunction

  function automatic tok_t take(tok_t s, logic [7:0] up);
    tok_t                r;
    logic [KW_COUNT-1:0] nl;
    r = s;
    if (!r.in_tok) begin
      r.in_tok = 1'b1;
      r.cnt    = '0;
      r.live   = '1;
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      nl[k] = r.live[k] && (r.cnt < TW'(kw_len(3'(k))))
              && (kw_char(3'(k), r.cnt[2:0]) == up);
    end
    r.live = nl;
    r.cnt  = r.cnt + 1'b1;
    // split an overlong token
    if (r.cnt >= TOK_LAST) r = finish(r);
    return r;
  endfunction

  logic          pend_r,  pend_nxt;
  logic [LW-1:0] len_r,   len_nxt;
  logic          ovf_r,   ovf_nxt;
  logic          ended_r, ended_nxt;
  tok_t          tok_r,   tok_nxt;

  logic       is_cr, is_lf, is_sep;
  logic [7:0] up;
  tok_t       fin;

  assign is_cr  = (rx_byte == CH_CR);
  assign is_lf  = (rx_byte == CH_LF);
  assign is_sep = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
  assign up     = (rx_byte >= CH_LOWER_A && rx_byte <= CH_LOWER_Z) ?
                  rx_byte - CASE_DIFF : rx_byte;
  assign emit   = !timeout && (is_cr || (is_lf && !pend_r));

  always_comb begin
    fin = finish(tok_r);
    if (ovf_r) begin
      outcome = OUT_TOO_LONG;
    end else begin
      case (fin.cmd)
        CMD_NONE:   outcome = OUT_BLANK;
        CMD_HELP:   outcome = OUT_HELP;
        CMD_STATUS: outcome = OUT_STATUS;
        CMD_SCAN: begin
          if (fin.med == MED_NONE)       outcome = OUT_NO_MEDIUM;
          else if (fin.act == ACT_NONE)  outcome = OUT_NO_ACTION;
          else if (fin.med == MED_WIFI)  outcome = OUT_WIFI_UNIMP;
          else if (fin.med != MED_BLE)   outcome = OUT_BAD_MEDIUM;
          else if (fin.act == ACT_START) outcome = OUT_BLE_START;
          else if (fin.act == ACT_STOP)  outcome = OUT_BLE_STOP;
          else                           outcome = OUT_BAD_ACTION;
        end
        default:    outcome = OUT_BAD_CMD;
      endcase
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    ended_nxt = ended_r;
    tok_nxt   = tok_r;
    if (step) begin
      if (timeout) begin
        pend_nxt = 1'b0;
      end else begin
        pend_nxt = is_cr;
        if (is_lf && pend_r) begin
          // drop LF of a CR LF pair
        end else if (is_cr || is_lf) begin
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          ended_nxt = 1'b0;
          tok_nxt   = '0;
        end else if (len_r == LEN_LAST) begin
          ovf_nxt = 1'b1;
        end else begin
          len_nxt = len_r + 1'b1;
          if (!ended_r) begin
            if (rx_byte == CH_NUL) begin
              ended_nxt = 1'b1;
              tok_nxt   = finish(tok_r);
            end else if (is_sep) begin
              tok_nxt = finish(tok_r);
            end else begin
              tok_nxt = take(tok_r, up);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      ended_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      pend_r  <= pend_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      ended_r <= ended_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

// File: src/console_command_line_parser_unit.sv
// Console command line parser. Takes one received byte or one read-timeout
// event per in_bus beat and gives one outcome code on out_bus for every line
// end (CR, or LF not directly after CR). A beat is taken every cycle unless
// the input stalls. Each item is held in the input register; when it advances,
// the parse state and, at a line end, the result register update from the
// input register. Input stalls only when a line-end byte waits in the input
// register while the result register still holds an outcome that out_bus has
// not taken.
`include "console_command_line_parser_unit_defines.svh"

module console_command_line_parser_unit import ccp_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ccp_in_if.sink    in_bus,
  ccp_out_if.source out_bus
);

  logic       in_v_r,    in_v_nxt;
  logic [7:0] byte_r;
  logic       timeout_r;
  logic       out_v_r,   out_v_nxt;
  logic [3:0] outcome_r;

  logic       advance;
  logic       emit;
  logic [3:0] outcome;

  ccp_parser #(
    .LINE_MAX  (LINE_MAX),
    .TOKEN_MAX (TOKEN_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (byte_r),
    .timeout (timeout_r),
    .emit    (emit),
    .outcome (outcome)
  );

  // advance unless a result would land on an untaken one
  assign advance       = in_v_r && (!emit || !out_v_r || out_bus.ready);
  assign in_bus.ready  = !in_v_r || advance;
  assign out_bus.valid = out_v_r;
  assign out_bus.outcome = outcome_r;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_bus.valid && in_bus.ready) in_v_nxt = 1'b1;
    else if (advance)                 in_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (advance && emit)     out_v_nxt = 1'b1;
    else if (out_bus.ready)  out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r    <= in_bus.rx_byte;
      timeout_r <= in_bus.timeout;
    end
    if (advance && emit) outcome_r <= outcome;
  end

  `CCP_ASSERT_NEXT(a_result_loaded, advance && emit, out_v_r && outcome_r == $past(outcome))
  `CCP_ASSERT_SAME(a_no_overwrite, out_v_r && !out_bus.ready, !(advance && emit))
  `CCP_ASSERT_SAME(a_timeout_silent, in_v_r && timeout_r, !emit)

endmodule
